[hdl/brl_pkg.sv]
package brl_pkg;

   // default list depth
   localparam int DEFAULT_CAPACITY = 128;

   // fixed field widths
   localparam int MODE_W     = 4;
   localparam int KEY_W      = 32;
   localparam int PAYLOAD_W  = 64;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 8;

   // operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND     = 4'd0,
      MODE_PREPEND    = 4'd1,
      MODE_SORTED     = 4'd2,
      MODE_REMOVE     = 4'd3,
      MODE_SWAP       = 4'd4,
      MODE_POP_FIRST  = 4'd5,
      MODE_POP_LAST   = 4'd6,
      MODE_READ       = 4'd7,
      MODE_FIND       = 4'd8
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_FULL   = 3'd1,
      STAT_EMPTY  = 3'd2,
      STAT_NOKEY  = 3'd3,
      STAT_BADPOS = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] entry_key;
      logic [PAYLOAD_W-1:0]    entry_payload;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] found_key;
      logic [PAYLOAD_W-1:0]    found_payload;
      logic [COUNT_W-1:0]      entry_count;
      logic                    is_full;
      logic                    is_empty;
   } rsp_type;

   // one stored record
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
   } record_type;

   // per-cell load select, at most one bit set
   typedef struct packed {
      logic take_new;
      logic take_left;
      logic take_right;
      logic take_last;
   } cell_ctl_type;

endpackage

[hdl/bounded_record_list_unit.sv]
// Bounded list of up to CAPACITY records (signed 32-bit key plus 64-bit payload)
// held in a row of cells, one record per cell. On accept every cell compares its
// key with the item's key; in the commit cycle all cells shift, load or hold at
// once and the result is registered. A new item is accepted only after the last
// one commits, though its result may still wait in the result register; a stalled
// result holds the commit cycle until the slot is free. Reads and lookups return
// the record at the lowest matching position; a failed read returns zero fields.
// Cells beyond the count hold stale data and are never reported.
module bounded_record_list_unit #(
   parameter int CAPACITY = brl_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brl_pkg::rsp_type  rsp_data
);
   import brl_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   fsm_type           state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           req_ff, req_in;
   record_type        last_ff, last_in;

   logic              accept, out_free, commit;
   record_type        new_rec;
   record_type        recs [CAPACITY];
   cell_ctl_type      ctls [CAPACITY];
   logic [CAPACITY-1:0] hit_v, lt_v, occ, hit_occ, ge_occ, hpre, gpre;
   logic [CAPACITY-1:0] first_hit, posel, sel, ins_at;
   logic [CAPACITY-1:0] take_new, take_left, take_right, take_last;
   logic              found, nonempty, notfull;
   logic [CW-1:0]     count_next;
   status_type        status;
   logic signed [KEY_W-1:0] rd_key;
   logic [PAYLOAD_W-1:0]    rd_payload;

   // handshake
   assign req_ready = (state_ff == FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == FSM_EXEC) && out_free;

   assign new_rec.key     = req_ff.entry_key;
   assign new_rec.payload = req_ff.entry_payload;

   // occupancy and per-position selects
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occ[i]   = (CW'(i) < count_ff);
         posel[i] = occ[i] && (XW'(req_ff.position) == XW'(i + 1));
      end
   end

   assign hit_occ   = hit_v & occ;
   assign ge_occ    = ~lt_v & occ;
   assign first_hit = hit_occ & ~(hpre << 1);
   assign found     = |hit_occ;
   assign nonempty  = (count_ff != '0);
   assign notfull   = (count_ff < CW'(CAPACITY));

   brl_scan #(.N(CAPACITY)) u_hit_scan (
      .bits_in    (hit_occ),
      .prefix_out (hpre)
   );

   brl_scan #(.N(CAPACITY)) u_ge_scan (
      .bits_in    (ge_occ),
      .prefix_out (gpre)
   );

   // operation decode for the commit cycle
   always_comb begin
      ins_at     = '0;
      take_new   = '0;
      take_left  = '0;
      take_right = '0;
      take_last  = '0;
      sel        = '0;
      status     = STAT_OK;
      count_next = count_ff;
      unique case (mode_type'(req_ff.mode)) inside
         MODE_APPEND, MODE_PREPEND, MODE_SORTED: begin
            if (notfull) begin
               if (mode_type'(req_ff.mode) == MODE_APPEND) begin
                  ins_at = ~occ;
               end else if (mode_type'(req_ff.mode) == MODE_PREPEND) begin
                  ins_at = '1;
               end else begin
                  ins_at = gpre | ~occ;
               end
               take_new   = ins_at & ~(ins_at << 1);
               take_left  = ins_at & (ins_at << 1);
               count_next = count_ff + CW'(1);
            end else begin
               status = STAT_FULL;
            end
         end
         MODE_REMOVE, MODE_SWAP: begin
            if (!nonempty) begin
               status = STAT_EMPTY;
            end else if (!found) begin
               status = STAT_NOKEY;
            end else begin
               if (mode_type'(req_ff.mode) == MODE_REMOVE) begin
                  take_right = hpre;
               end else begin
                  take_last = first_hit;
               end
               count_next = count_ff - CW'(1);
            end
         end
         MODE_POP_FIRST, MODE_POP_LAST: begin
            if (!nonempty) begin
               status = STAT_EMPTY;
            end else begin
               if (mode_type'(req_ff.mode) == MODE_POP_FIRST) begin
                  take_right = '1;
               end
               count_next = count_ff - CW'(1);
            end
         end
         MODE_READ: begin
            sel = posel;
            if (!(|posel)) begin
               status = STAT_BADPOS;
            end
         end
         MODE_FIND: begin
            sel = first_hit;
            if (!found) begin
               status = STAT_NOKEY;
            end
         end
         default: begin
         end
      endcase
   end

   // record readout, AND-OR over the one-hot select
   always_comb begin
      rd_key     = '0;
      rd_payload = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_key     = rd_key | (recs[i].key & {KEY_W{sel[i]}});
         rd_payload = rd_payload | (recs[i].payload & {PAYLOAD_W{sel[i]}});
      end
   end

   // tail record, picked while the item is accepted
   always_comb begin
      last_in = last_ff;
      if (accept) begin
         last_in = '0;
         for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i + 1) == count_ff) begin
               last_in = last_in | recs[i];
            end
         end
      end
   end

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      record_type left_rec, right_rec;

      if (g == 0) begin : g_first
         assign left_rec = new_rec;
      end else begin : g_mid_l
         assign left_rec = recs[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_rec = recs[g];
      end else begin : g_mid_r
         assign right_rec = recs[g+1];
      end

      assign ctls[g].take_new   = commit && take_new[g];
      assign ctls[g].take_left  = commit && take_left[g];
      assign ctls[g].take_right = commit && take_right[g];
      assign ctls[g].take_last  = commit && take_last[g];

      brl_cell u_cell (
         .clock     (clock),
         .capture   (accept),
         .probe_key (req_data.entry_key),
         .ctl       (ctls[g]),
         .new_rec   (new_rec),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .last_rec  (last_ff),
         .rec       (recs[g]),
         .hit       (hit_v[g]),
         .lt        (lt_v[g])
      );
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // request, count and result registers
   always_comb begin
      req_in       = accept ? req_data : req_ff;
      count_in     = commit ? count_next : count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (commit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = status;
         rsp_in.found_key     = rd_key;
         rsp_in.found_payload = rd_payload;
         rsp_in.entry_count   = COUNT_W'(count_next);
         rsp_in.is_full       = (count_next == CW'(CAPACITY));
         rsp_in.is_empty      = (count_next == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("record count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)) ||
      (count_ff == $past(count_ff) - CW'(1)))
      else $error("record count moved by more than one");

   a_one_new: assert property (@(posedge clock) disable iff (reset)
      $onehot0(take_new))
      else $error("new record loaded into more than one cell");

   a_one_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel))
      else $error("readout select not one-hot");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_EXEC))
      else $error("result raised outside the commit cycle");

endmodule

[hdl/brl_cell.sv]
module brl_cell (
   input  logic                              clock,
   input  logic                              capture,
   input  logic signed [brl_pkg::KEY_W-1:0]  probe_key,
   input  brl_pkg::cell_ctl_type             ctl,
   input  brl_pkg::record_type               new_rec,
   input  brl_pkg::record_type               left_rec,
   input  brl_pkg::record_type               right_rec,
   input  brl_pkg::record_type               last_rec,
   output brl_pkg::record_type               rec,
   output logic                              hit,
   output logic                              lt
);
   import brl_pkg::*;

   record_type rec_ff, rec_in;
   logic       hit_ff, hit_in;
   logic       lt_ff, lt_in;

   // record load from the request, a neighbor or the tail record
   always_comb begin
      rec_in = rec_ff;
      if (ctl.take_new) begin
         rec_in = new_rec;
      end else if (ctl.take_left) begin
         rec_in = left_rec;
      end else if (ctl.take_right) begin
         rec_in = right_rec;
      end else if (ctl.take_last) begin
         rec_in = last_rec;
      end
   end

   // key compare against the incoming item, held for the commit cycle
   always_comb begin
      hit_in = hit_ff;
      lt_in  = lt_ff;
      if (capture) begin
         hit_in = (rec_ff.key == probe_key);
         lt_in  = ($signed(rec_ff.key) < $signed(probe_key));
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      hit_ff <= hit_in;
      lt_ff  <= lt_in;
   end

   assign rec = rec_ff;
   assign hit = hit_ff;
   assign lt  = lt_ff;

endmodule

[hdl/brl_scan.sv]
module brl_scan #(
   parameter int N = brl_pkg::DEFAULT_CAPACITY
) (
   input  logic [N-1:0] bits_in,
   output logic [N-1:0] prefix_out
);

   // inclusive prefix OR toward higher indexes, log-depth doubling
   always_comb begin
      logic [N-1:0] acc;
      acc = bits_in;
      for (int lv = 0; (1 << lv) < N; lv++) begin
         acc = acc | (acc << (1 << lv));
      end
      prefix_out = acc;
   end

endmodule

[verif/bounded_record_list_unit_test.sv]
module bounded_record_list_unit_test;
   import brl_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;

   // mode codes the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

   localparam int RANDOM_ITEMS = 160;
   localparam int DRAIN_LIMIT  = 5000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // list contents as the block should hold them
   logic signed [KEY_W-1:0] list_keys [CAPACITY];
   logic [PAYLOAD_W-1:0]    list_payloads [CAPACITY];
   int                      list_count = 0;

   rsp_type expected_rsps [$];
   int      fail_count = 0;

   // sender pacing
   bit pacing_on  = 1'b1;
   int burst_left = 0;

   // receiver stall pattern and long hold-off request
   int hold_request = 0;
   int hold_left    = 0;
   int stall_span   = 0;
   int stall_style  = 0;
   int rx_tick      = 0;

   bounded_record_list_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // lowest index holding key, or list_count when absent
   function automatic int locate_key(input logic signed [KEY_W-1:0] key);
      int idx;
      idx = 0;
      while (idx < list_count && list_keys[idx] != key) idx++;
      return idx;
   endfunction

   // applies one operation to the list and returns the result it should give
   function automatic rsp_type predict_list_op(input req_type item);
      rsp_type                 r;
      int                      idx;
      int                      j;
      logic signed [KEY_W-1:0] key;
      r   = '0;
      key = item.entry_key;
      r.status = STAT_OK;
      case (item.mode)
         MODE_APPEND, MODE_PREPEND, MODE_SORTED: begin
            if (list_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               if (item.mode == MODE_APPEND) begin
                  idx = list_count;
               end else if (item.mode == MODE_PREPEND) begin
                  idx = 0;
               end else begin
                  // goes ahead of the first key not less than the new one
                  idx = 0;
                  while (idx < list_count && list_keys[idx] < key) idx++;
               end
               for (j = list_count; j > idx; j--) begin
                  list_keys[j]     = list_keys[j-1];
                  list_payloads[j] = list_payloads[j-1];
               end
               list_keys[idx]     = key;
               list_payloads[idx] = item.entry_payload;
               list_count++;
            end
         end
         MODE_REMOVE, MODE_SWAP: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               idx = locate_key(key);
               if (idx >= list_count) begin
                  r.status = STAT_NOKEY;
               end else if (item.mode == MODE_REMOVE) begin
                  for (j = idx; j < list_count - 1; j++) begin
                     list_keys[j]     = list_keys[j+1];
                     list_payloads[j] = list_payloads[j+1];
                  end
                  list_count--;
               end else begin
                  list_keys[idx]     = list_keys[list_count-1];
                  list_payloads[idx] = list_payloads[list_count-1];
                  list_count--;
               end
            end
         end
         MODE_POP_FIRST, MODE_POP_LAST: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               if (item.mode == MODE_POP_FIRST) begin
                  for (j = 0; j < list_count - 1; j++) begin
                     list_keys[j]     = list_keys[j+1];
                     list_payloads[j] = list_payloads[j+1];
                  end
               end
               list_count--;
            end
         end
         MODE_READ: begin
            if (item.position == 0 || item.position > list_count) begin
               r.status = STAT_BADPOS;
            end else begin
               r.found_key     = list_keys[item.position-1];
               r.found_payload = list_payloads[item.position-1];
            end
         end
         MODE_FIND: begin
            idx = locate_key(key);
            if (idx >= list_count) begin
               r.status = STAT_NOKEY;
            end else begin
               r.found_key     = list_keys[idx];
               r.found_payload = list_payloads[idx];
            end
         end
         default: begin
         end
      endcase
      r.entry_count = list_count[COUNT_W-1:0];
      r.is_full     = (list_count == CAPACITY);
      r.is_empty    = (list_count == 0);
      return r;
   endfunction

   function automatic req_type make_req(input logic [MODE_W-1:0] mode,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [PAYLOAD_W-1:0] payload,
                                        input logic [POS_W-1:0] pos);
      req_type item;
      item.mode          = mode;
      item.entry_key     = key;
      item.entry_payload = payload;
      item.position      = pos;
      return item;
   endfunction

   // mostly keys already stored or near zero, so removals and finds hit
   function automatic logic signed [KEY_W-1:0] pick_key();
      int roll;
      int near;
      roll = $urandom_range(0, 19);
      near = $urandom_range(0, 8);
      if (roll < 8 && list_count > 0) return list_keys[$urandom_range(0, list_count - 1)];
      if (roll < 14) return near - 4;
      if (roll == 14) return 32'sh8000_0000;
      if (roll == 15) return 32'sh7fff_ffff;
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7 && list_count > 0) return POS_W'($urandom_range(1, list_count));
      if (roll == 7) return POS_W'(list_count + 1);
      if (roll == 8) return '0;
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      return {$urandom, $urandom};
   endfunction

   // offer one item and hold it until accepted, then record its expected result
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_list_op(item));
   endtask

   // send, then, when pacing is on, drop valid for a random gap at the end of each burst
   task automatic send_paced(input req_type item);
      int gap;
      send_item(item);
      if (pacing_on) begin
         if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // every removal and lookup on an empty list
   task automatic test_empty_list();
      send_paced(make_req(MODE_POP_FIRST, 0, 0, 0));
      send_paced(make_req(MODE_POP_LAST, 0, 0, 0));
      send_paced(make_req(MODE_REMOVE, 3, 0, 0));
      send_paced(make_req(MODE_SWAP, -3, 0, 0));
      send_paced(make_req(MODE_FIND, 0, 0, 0));
      send_paced(make_req(MODE_READ, 0, 0, 8'd0));
      send_paced(make_req(MODE_READ, 0, 0, 8'd1));
      send_paced(make_req(MODE_SPARE_LO, $urandom, pick_payload(), 8'hff));
   endtask

   // each operation at least once, extreme keys and payloads, duplicates, bad positions
   task automatic test_directed_ops();
      send_paced(make_req(MODE_APPEND, 32'sh7fff_ffff, '1, 0));
      send_paced(make_req(MODE_PREPEND, 32'sh8000_0000, '0, 0));
      send_paced(make_req(MODE_SORTED, 0, 64'h0123_4567_89ab_cdef, 0));
      send_paced(make_req(MODE_SORTED, 0, 64'hfedc_ba98_7654_3210, 0));
      send_paced(make_req(MODE_SORTED, -1, 64'h5555_aaaa_5555_aaaa, 0));
      send_paced(make_req(MODE_APPEND, 5, 64'haaaa_5555_aaaa_5555, 0));
      send_paced(make_req(MODE_READ, 0, 0, 8'd0));
      send_paced(make_req(MODE_READ, 0, 0, 8'd1));
      send_paced(make_req(MODE_READ, 0, 0, POS_W'(list_count)));
      send_paced(make_req(MODE_READ, 0, 0, POS_W'(list_count + 1)));
      send_paced(make_req(MODE_READ, 0, 0, 8'hff));
      send_paced(make_req(MODE_FIND, 0, 0, 0));
      send_paced(make_req(MODE_FIND, 12345, 0, 0));
      send_paced(make_req(MODE_FIND, 32'sh7fff_ffff, 0, 0));
      send_paced(make_req(MODE_REMOVE, 0, 0, 0));
      send_paced(make_req(MODE_SWAP, 32'sh8000_0000, 0, 0));
      send_paced(make_req(MODE_REMOVE, 12345, 0, 0));
      send_paced(make_req(MODE_SWAP, 12345, 0, 0));
      send_paced(make_req(MODE_POP_FIRST, 0, 0, 0));
      send_paced(make_req(MODE_POP_LAST, 0, 0, 0));
      send_paced(make_req(MODE_SPARE_HI, $urandom, pick_payload(), POS_W'($urandom)));
      send_paced(make_req(MODE_READ, 0, 0, 8'd1));
   endtask

   // fill to capacity, try every insert, reads, a find and a swap while full, then drain to empty
   task automatic test_full_list();
      logic [MODE_W-1:0] mode;
      while (list_count < CAPACITY) begin
         mode = MODE_W'($urandom_range(MODE_APPEND, MODE_SORTED));
         send_paced(make_req(mode, pick_key(), pick_payload(), 0));
      end
      send_paced(make_req(MODE_APPEND, 1, pick_payload(), 0));
      send_paced(make_req(MODE_PREPEND, 2, pick_payload(), 0));
      send_paced(make_req(MODE_SORTED, 3, pick_payload(), 0));
      send_paced(make_req(MODE_READ, 0, 0, POS_W'(CAPACITY)));
      send_paced(make_req(MODE_READ, 0, 0, POS_W'(CAPACITY + 1)));
      send_paced(make_req(MODE_FIND, list_keys[CAPACITY-1], 0, 0));
      send_paced(make_req(MODE_SWAP, list_keys[0], 0, 0));
      send_paced(make_req(MODE_SORTED, pick_key(), pick_payload(), 0));
      while (list_count > 0) begin
         mode = MODE_W'($urandom_range(MODE_REMOVE, MODE_POP_LAST));
         send_paced(make_req(mode, pick_key(), 0, 0));
      end
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_input_backpressure();
      int n;
      pacing_on    = 1'b0;
      hold_request = 80;
      for (n = 0; n < 24; n++) begin
         send_item(make_req(MODE_W'($urandom_range(MODE_APPEND, MODE_FIND)), pick_key(),
                            pick_payload(), pick_position()));
      end
      pacing_on = 1'b1;
   endtask

   // random mix, weighted by fill level to keep the list moving across its range
   task automatic test_random_mix();
      int                n;
      int                roll;
      int                insert_pct;
      logic [MODE_W-1:0] mode;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) pacing_on = ($urandom_range(0, 3) != 0);
         if (n == RANDOM_ITEMS / 2) hold_request = 60;
         insert_pct = (list_count < 16) ? 60 : (list_count > 112) ? 25 : 42;
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) begin
            mode = MODE_W'($urandom_range(MODE_APPEND, MODE_SORTED));
         end else if (roll < 80) begin
            mode = MODE_W'($urandom_range(MODE_REMOVE, MODE_POP_LAST));
         end else if (roll < 95) begin
            mode = MODE_W'($urandom_range(MODE_READ, MODE_FIND));
         end else begin
            mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end
         send_paced(make_req(mode, pick_key(), pick_payload(), pick_position()));
      end
      pacing_on = 1'b1;
   endtask

   // receiver: switches stall style every so often, honors long hold-off requests
   always @(posedge clock) begin
      rx_tick++;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (stall_span == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_span  = $urandom_range(20, 120);
      end else begin
         stall_span--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= (rx_tick % 3 == 0);
         endcase
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.found_key !== want.found_key) begin
               $error("found_key mismatch: expected %0d, got %0d",
                      want.found_key, rsp_data.found_key);
               fail_count++;
            end
            if (rsp_data.found_payload !== want.found_payload) begin
               $error("found_payload mismatch: expected %h, got %h",
                      want.found_payload, rsp_data.found_payload);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
            if (rsp_data.is_full !== want.is_full) begin
               $error("is_full mismatch: expected %0b, got %0b", want.is_full, rsp_data.is_full);
               fail_count++;
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               $error("is_empty mismatch: expected %0b, got %0b",
                      want.is_empty, rsp_data.is_empty);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : main
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_directed_ops();
      test_full_list();
      test_input_backpressure();
      test_random_mix();

      // drain outstanding results, then wait for anything stray
      req_valid <= 1'b0;
      waited = 0;
      while (expected_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/brl_pkg.sv
hdl/brl_cell.sv
hdl/brl_scan.sv
hdl/bounded_record_list_unit.sv
verif/bounded_record_list_unit_test.sv
